>>> rtl/urs_filt_pkg.sv
package urs_filt_pkg;

   localparam int WINDOW     = 5;
   localparam int WEIGHT_SUM = WINDOW * (WINDOW + 1) / 2;

   localparam int ECHO_W  = 16;
   localparam int SS_W    = 10;
   localparam int RATE_W  = 8;
   localparam int PROD_W  = ECHO_W + SS_W;
   localparam int RANGE_W = PROD_W - 1;
   localparam int DIFF_W  = RANGE_W + 1;
   localparam int RAW_W   = DIFF_W + RATE_W + 1;
   localparam int SPEED_W = 34;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SS_W;

   localparam logic [CSR_IDX_W-1:0] REG_SOUND_SPEED = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_RATE = CSR_IDX_W'(1);

   localparam logic [SS_W-1:0]   SOUND_SPEED_RESET = SS_W'(340);
   localparam logic [RATE_W-1:0] SAMPLE_RATE_RESET = RATE_W'(20);

   localparam int WGT_W  = $clog2(WINDOW + 1);
   localparam int SUM_W  = $clog2(WEIGHT_SUM + 1);
   localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int RACC_W = RANGE_W + SUM_W;
   localparam int SACC_W = RAW_W + SUM_W;

   localparam int DIV_BITS  = 4;
   localparam int DIV_STEPS = (SACC_W + DIV_BITS - 1) / DIV_BITS;
   localparam int DIVD_W    = DIV_STEPS * DIV_BITS;
   localparam int REM_W     = SUM_W;
   localparam logic [REM_W:0] DIVISOR = (REM_W + 1)'(WEIGHT_SUM);

   localparam int CNT_MAX = (WINDOW > DIV_STEPS) ? WINDOW : DIV_STEPS;
   localparam int CNT_W   = $clog2(CNT_MAX);

   typedef struct packed {
      logic             load_range;
      logic             calc_diff;
      logic             shift_ring;
      logic             acc_en;
      logic             div_load;
      logic             div_step;
      logic             out_load;
      logic [IDX_W-1:0] idx;
   } urs_cmd_type;

endpackage

>>> rtl/urs_filt_dp.sv
module urs_filt_dp (
   input  logic                                      clock,
   input  logic                                      reset,
   input  urs_filt_pkg::urs_cmd_type                 cmd,
   input  logic [urs_filt_pkg::ECHO_W-1:0]           req_echo_time_us,
   input  logic                                      csr_write_en,
   input  logic [urs_filt_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [urs_filt_pkg::CSR_DATA_W-1:0]       csr_write_data,
   output logic [urs_filt_pkg::RANGE_W-1:0]          rsp_filtered_range_um,
   output logic signed [urs_filt_pkg::SPEED_W-1:0]   rsp_filtered_speed_ums
);

   localparam int DW = urs_filt_pkg::DIVD_W + urs_filt_pkg::REM_W;

   logic [urs_filt_pkg::SS_W-1:0]   ss_ff;
   logic [urs_filt_pkg::RATE_W-1:0] rate_ff;

   logic [urs_filt_pkg::RANGE_W-1:0]        range_ring_ff [urs_filt_pkg::WINDOW];
   logic signed [urs_filt_pkg::RAW_W-1:0]   speed_ring_ff [urs_filt_pkg::WINDOW];
   logic [urs_filt_pkg::RANGE_W-1:0]        last_ff;

   logic [urs_filt_pkg::PROD_W-1:0]         prod;
   logic [urs_filt_pkg::RANGE_W-1:0]        range_ff;
   logic [urs_filt_pkg::RANGE_W-1:0]        range_in;
   logic signed [urs_filt_pkg::DIFF_W-1:0]  diff_ff;
   logic signed [urs_filt_pkg::DIFF_W-1:0]  diff_in;
   logic signed [urs_filt_pkg::RAW_W-1:0]   diff_ext;
   logic signed [urs_filt_pkg::RAW_W-1:0]   rate_ext;
   logic signed [urs_filt_pkg::RAW_W-1:0]   raw_speed;

   logic [urs_filt_pkg::RACC_W-1:0]         racc_ff;
   logic [urs_filt_pkg::RACC_W-1:0]         racc_in;
   logic signed [urs_filt_pkg::SACC_W-1:0]  sacc_ff;
   logic signed [urs_filt_pkg::SACC_W-1:0]  sacc_in;
   logic [urs_filt_pkg::WGT_W-1:0]          wgt;
   logic signed [urs_filt_pkg::SACC_W-1:0]  stap;
   logic signed [urs_filt_pkg::SACC_W-1:0]  swgt;
   logic [urs_filt_pkg::SACC_W-1:0]         smag;

   logic [DW-1:0]                           rdiv_ff;
   logic [DW-1:0]                           rdiv_in;
   logic [DW-1:0]                           sdiv_ff;
   logic [DW-1:0]                           sdiv_in;
   logic                                    sneg_ff;
   logic [urs_filt_pkg::DIVD_W-1:0]         rq;
   logic [urs_filt_pkg::DIVD_W-1:0]         sq;
   logic [urs_filt_pkg::DIVD_W-1:0]         sres;

   // restoring division by the weight sum, DIV_BITS quotient bits per call
   function automatic logic [DW-1:0] div_iter(input logic [DW-1:0] st);
      logic [urs_filt_pkg::REM_W-1:0]  rem;
      logic [urs_filt_pkg::DIVD_W-1:0] dq;
      logic [urs_filt_pkg::REM_W:0]    t;
      rem = st[DW-1:urs_filt_pkg::DIVD_W];
      dq  = st[urs_filt_pkg::DIVD_W-1:0];
      for (int i = 0; i < urs_filt_pkg::DIV_BITS; i++) begin
         t  = {rem, dq[urs_filt_pkg::DIVD_W-1]};
         dq = {dq[urs_filt_pkg::DIVD_W-2:0], 1'b0};
         if (t >= urs_filt_pkg::DIVISOR) begin
            t     = t - urs_filt_pkg::DIVISOR;
            dq[0] = 1'b1;
         end
         rem = t[urs_filt_pkg::REM_W-1:0];
      end
      return {rem, dq};
   endfunction

   always_comb begin
      prod     = urs_filt_pkg::PROD_W'(req_echo_time_us) * urs_filt_pkg::PROD_W'(ss_ff);
      range_in = prod[urs_filt_pkg::PROD_W-1:1];
      diff_in  = $signed({1'b0, range_ff}) - $signed({1'b0, last_ff});
      diff_ext = urs_filt_pkg::RAW_W'(diff_ff);
      rate_ext = urs_filt_pkg::RAW_W'(rate_ff);
      raw_speed = diff_ext * rate_ext;

      wgt  = urs_filt_pkg::WGT_W'(urs_filt_pkg::WINDOW) - urs_filt_pkg::WGT_W'(cmd.idx);
      stap = urs_filt_pkg::SACC_W'(speed_ring_ff[cmd.idx]);
      swgt = urs_filt_pkg::SACC_W'(wgt);
      racc_in = racc_ff + urs_filt_pkg::RACC_W'(range_ring_ff[cmd.idx])
                        * urs_filt_pkg::RACC_W'(wgt);
      sacc_in = sacc_ff + stap * swgt;

      smag    = sacc_ff[urs_filt_pkg::SACC_W-1] ? urs_filt_pkg::SACC_W'(-sacc_ff)
                                                : urs_filt_pkg::SACC_W'(sacc_ff);
      rdiv_in = div_iter(rdiv_ff);
      sdiv_in = div_iter(sdiv_ff);

      rq   = rdiv_ff[urs_filt_pkg::DIVD_W-1:0];
      sq   = sdiv_ff[urs_filt_pkg::DIVD_W-1:0];
      sres = sneg_ff ? (~sq + urs_filt_pkg::DIVD_W'(1)) : sq;
   end

   // configuration, rings and feedback range
   always_ff @(posedge clock) begin
      if (reset) begin
         ss_ff   <= urs_filt_pkg::SOUND_SPEED_RESET;
         rate_ff <= urs_filt_pkg::SAMPLE_RATE_RESET;
         last_ff <= '0;
         for (int i = 0; i < urs_filt_pkg::WINDOW; i++) begin
            range_ring_ff[i] <= '0;
            speed_ring_ff[i] <= '0;
         end
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               urs_filt_pkg::REG_SOUND_SPEED: ss_ff <= csr_write_data[urs_filt_pkg::SS_W-1:0];
               urs_filt_pkg::REG_SAMPLE_RATE:
                  rate_ff <= csr_write_data[urs_filt_pkg::RATE_W-1:0];
               default: ;
            endcase
         end
         if (cmd.shift_ring) begin
            for (int i = urs_filt_pkg::WINDOW - 1; i > 0; i--) begin
               range_ring_ff[i] <= range_ring_ff[i-1];
               speed_ring_ff[i] <= speed_ring_ff[i-1];
            end
            range_ring_ff[0] <= range_ff;
            speed_ring_ff[0] <= raw_speed;
         end
         if (cmd.out_load) begin
            last_ff <= rq[urs_filt_pkg::RANGE_W-1:0];
         end
      end
   end

   // working registers and result payload
   always_ff @(posedge clock) begin
      if (cmd.load_range) begin
         range_ff <= range_in;
      end
      if (cmd.calc_diff) begin
         diff_ff <= diff_in;
      end
      if (cmd.shift_ring) begin
         racc_ff <= '0;
         sacc_ff <= '0;
      end else if (cmd.acc_en) begin
         racc_ff <= racc_in;
         sacc_ff <= sacc_in;
      end
      if (cmd.div_load) begin
         rdiv_ff <= DW'(racc_ff);
         sdiv_ff <= DW'(smag);
         sneg_ff <= sacc_ff[urs_filt_pkg::SACC_W-1];
      end else if (cmd.div_step) begin
         rdiv_ff <= rdiv_in;
         sdiv_ff <= sdiv_in;
      end
      if (cmd.out_load) begin
         rsp_filtered_range_um  <= rq[urs_filt_pkg::RANGE_W-1:0];
         rsp_filtered_speed_ums <= $signed(sres[urs_filt_pkg::SPEED_W-1:0]);
      end
   end

endmodule

>>> rtl/urs_filt_ctrl.sv
module urs_filt_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output urs_filt_pkg::urs_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIFF  = 3'd1;
   localparam logic [2:0] ST_SPEED = 3'd2;
   localparam logic [2:0] ST_ACC   = 3'd3;
   localparam logic [2:0] ST_DIVLD = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   localparam logic [urs_filt_pkg::CNT_W-1:0] ACC_LAST =
      urs_filt_pkg::CNT_W'(urs_filt_pkg::WINDOW - 1);
   localparam logic [urs_filt_pkg::CNT_W-1:0] DIV_LAST =
      urs_filt_pkg::CNT_W'(urs_filt_pkg::DIV_STEPS - 1);

   logic [2:0]                       state_ff;
   logic [2:0]                       state_in;
   logic [urs_filt_pkg::CNT_W-1:0]   cnt_ff;
   logic [urs_filt_pkg::CNT_W-1:0]   cnt_in;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic                             out_free;

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      cmd.idx      = cnt_ff[urs_filt_pkg::IDX_W-1:0];
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_range = 1'b1;
               state_in       = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.calc_diff = 1'b1;
            state_in      = ST_SPEED;
         end
         ST_SPEED: begin
            cmd.shift_ring = 1'b1;
            cnt_in         = '0;
            state_in       = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_en = 1'b1;
            if (cnt_ff == ACC_LAST) begin
               cnt_in   = '0;
               state_in = ST_DIVLD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIVLD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == DIV_LAST) begin
               cnt_in   = '0;
               state_in = ST_OUT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // an accepted transfer starts the sequence
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_DIFF))
      else $error("accepted transfer did not start processing");

   // a new result appears only from the output state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_OUT))
      else $error("result valid raised outside output state");

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(cnt_ff) || state_ff != ST_IDLE))
      else $error("pending result dropped");

   // tap and step counters stay in range
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ACC) |-> (cnt_ff <= ACC_LAST)) and
      ((state_ff == ST_DIV) |-> (cnt_ff <= DIV_LAST)))
      else $error("sequence counter out of range");

endmodule

>>> rtl/ultrasonic_range_speed_filter_top.sv
// Ultrasonic range and speed filter. Each echo time transfer (microseconds)
// becomes a range in micrometres (echo * sound speed / 2) and a raw speed
// (range minus the previous filtered range, times the sample rate); both are
// smoothed by a linear weighted average over the last WINDOW items, newest
// weight WINDOW down to 1, divided by WINDOW*(WINDOW+1)/2 with truncation
// toward zero. One item is processed at a time: the weighted sum walks the
// window one tap per cycle, and the division by the weight sum retires 4
// quotient bits per cycle over the 39-bit speed sum. A finished result sits
// in the output register, so a new item may be taken while it waits. The
// history starts as zeros after reset and those zeros count in the average
// until WINDOW items have arrived. Register 0 is the sound speed (m/s,
// reset 340), register 1 the sample rate (Hz, reset 20); write them only
// while the block is idle.
module ultrasonic_range_speed_filter_top (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [urs_filt_pkg::ECHO_W-1:0]           req_echo_time_us,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [urs_filt_pkg::RANGE_W-1:0]          rsp_filtered_range_um,
   output logic signed [urs_filt_pkg::SPEED_W-1:0]   rsp_filtered_speed_ums,
   input  logic                                      csr_write_en,
   input  logic [urs_filt_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [urs_filt_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   urs_filt_pkg::urs_cmd_type cmd;

   urs_filt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   urs_filt_dp u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .req_echo_time_us       (req_echo_time_us),
      .csr_write_en           (csr_write_en),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data),
      .rsp_filtered_range_um  (rsp_filtered_range_um),
      .rsp_filtered_speed_ums (rsp_filtered_speed_ums)
   );

endmodule

>>> tb/sv/tb_ultrasonic_range_speed_filter_top.sv
module tb_ultrasonic_range_speed_filter_top;

   typedef struct {
      logic [urs_filt_pkg::RANGE_W-1:0]        range_um;
      logic signed [urs_filt_pkg::SPEED_W-1:0] speed_ums;
   } filt_result_type;

   logic                                     clock;
   logic                                     reset;
   logic                                     req_valid;
   logic                                     req_stall;
   logic [urs_filt_pkg::ECHO_W-1:0]          req_echo_time_us;
   logic                                     rsp_valid;
   logic                                     rsp_stall;
   logic [urs_filt_pkg::RANGE_W-1:0]         rsp_filtered_range_um;
   logic signed [urs_filt_pkg::SPEED_W-1:0]  rsp_filtered_speed_ums;
   logic                                     csr_write_en;
   logic [urs_filt_pkg::CSR_IDX_W-1:0]       csr_index;
   logic [urs_filt_pkg::CSR_DATA_W-1:0]      csr_write_data;

   // filter state as predicted by the testbench
   logic [urs_filt_pkg::SS_W-1:0]            snd_speed;
   logic [urs_filt_pkg::RATE_W-1:0]          smp_rate;
   logic [urs_filt_pkg::RANGE_W-1:0]         range_hist [urs_filt_pkg::WINDOW];
   logic signed [urs_filt_pkg::RAW_W-1:0]    speed_hist [urs_filt_pkg::WINDOW];
   int                                       wr_slot;
   logic [urs_filt_pkg::RANGE_W-1:0]         last_avg_range;

   filt_result_type                          filt_due_q [$];
   int                                       error_count;
   int                                       item_count;
   int                                       result_count;
   int                                       setting_count;
   bit                                       idle_on;
   logic [urs_filt_pkg::ECHO_W-1:0]          drift_echo;

   ultrasonic_range_speed_filter_top uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_echo_time_us       (req_echo_time_us),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_filtered_range_um  (rsp_filtered_range_um),
      .rsp_filtered_speed_ums (rsp_filtered_speed_ums),
      .csr_write_en           (csr_write_en),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic filt_result_type filt_predict(
      input logic [urs_filt_pkg::ECHO_W-1:0] echo);
      filt_result_type res;
      longint          range_v;
      longint          speed_v;
      longint          racc;
      longint          sacc;
      int              slot;
      range_v = (longint'(echo) * longint'(snd_speed)) >>> 1;
      speed_v = (range_v - longint'(last_avg_range)) * longint'(smp_rate);
      if (wr_slot >= urs_filt_pkg::WINDOW) wr_slot = 0;
      range_hist[wr_slot] = range_v[urs_filt_pkg::RANGE_W-1:0];
      speed_hist[wr_slot] = speed_v[urs_filt_pkg::RAW_W-1:0];
      slot = wr_slot;
      racc = 0;
      sacc = 0;
      for (int k = 0; k < urs_filt_pkg::WINDOW; k++) begin
         racc += longint'(range_hist[slot]) * longint'(urs_filt_pkg::WINDOW - k);
         sacc += longint'(speed_hist[slot]) * longint'(urs_filt_pkg::WINDOW - k);
         slot = (slot == 0) ? urs_filt_pkg::WINDOW - 1 : slot - 1;
      end
      wr_slot = (wr_slot + 1 >= urs_filt_pkg::WINDOW) ? 0 : wr_slot + 1;
      racc = racc / longint'(urs_filt_pkg::WEIGHT_SUM);
      sacc = sacc / longint'(urs_filt_pkg::WEIGHT_SUM);
      res.range_um  = racc[urs_filt_pkg::RANGE_W-1:0];
      res.speed_ums = sacc[urs_filt_pkg::SPEED_W-1:0];
      last_avg_range = res.range_um;
      return res;
   endfunction

   task automatic send_echo(input logic [urs_filt_pkg::ECHO_W-1:0] echo);
      int gap;
      gap = idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_echo_time_us = echo;
      do @(posedge clock); while (!(req_valid && !req_stall));
      filt_due_q.push_back(filt_predict(echo));
      item_count++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // wait for all outstanding results, then let the pipeline settle
   task automatic drain_results();
      int waited;
      req_valid = 1'b0;
      waited = 0;
      while (filt_due_q.size() != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      if (filt_due_q.size() != 0) begin
         $display("%0t missing results: expected %0d more actual 0",
                  $time, filt_due_q.size());
         error_count++;
         filt_due_q.delete();
      end
      repeat (25) @(negedge clock);
   endtask

   task automatic write_reg(input logic [urs_filt_pkg::CSR_IDX_W-1:0] idx,
                            input logic [urs_filt_pkg::CSR_DATA_W-1:0] data);
      csr_write_en   = 1'b1;
      csr_index      = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_en = 1'b0;
      if (idx == urs_filt_pkg::REG_SOUND_SPEED) begin
         snd_speed = data[urs_filt_pkg::SS_W-1:0];
      end else if (idx == urs_filt_pkg::REG_SAMPLE_RATE) begin
         smp_rate = data[urs_filt_pkg::RATE_W-1:0];
      end
      setting_count++;
   endtask

   // result side back-pressure
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         n = idle_on ? $urandom_range(0, 9) : 0;
         if (n > 0) begin
            rsp_stall = 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      filt_result_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (filt_due_q.size() == 0) begin
            $display("%0t unexpected transfer: expected none actual range %0d speed %0d",
                     $time, rsp_filtered_range_um, rsp_filtered_speed_ums);
            error_count++;
         end else begin
            due = filt_due_q.pop_front();
            if (rsp_filtered_range_um !== due.range_um) begin
               $display("%0t range mismatch: expected %0d actual %0d",
                        $time, due.range_um, rsp_filtered_range_um);
               error_count++;
            end
            if (rsp_filtered_speed_ums !== due.speed_ums) begin
               $display("%0t speed mismatch: expected %0d actual %0d",
                        $time, due.speed_ums, rsp_filtered_speed_ums);
               error_count++;
            end
         end
      end
   end

   function automatic logic [urs_filt_pkg::ECHO_W-1:0] random_echo();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2, 3: begin
            return urs_filt_pkg::ECHO_W'($urandom_range(0, 65535));
         end
         4: begin
            return urs_filt_pkg::ECHO_W'($urandom_range(0, 2000));
         end
         5: begin
            return $urandom_range(0, 1) ? '1 : '0;
         end
         default: begin
            // slowly moving target
            drift_echo = drift_echo + urs_filt_pkg::ECHO_W'($urandom_range(0, 400))
                         - urs_filt_pkg::ECHO_W'(200);
            return drift_echo;
         end
      endcase
   endfunction

   function automatic logic [urs_filt_pkg::CSR_DATA_W-1:0] pick_speed_setting();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return urs_filt_pkg::CSR_DATA_W'(1023);
         2:       return urs_filt_pkg::SOUND_SPEED_RESET;
         default: return urs_filt_pkg::CSR_DATA_W'($urandom_range(0, 1023));
      endcase
   endfunction

   function automatic logic [urs_filt_pkg::CSR_DATA_W-1:0] pick_rate_setting();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return urs_filt_pkg::CSR_DATA_W'(255);
         2:       return urs_filt_pkg::CSR_DATA_W'(urs_filt_pkg::SAMPLE_RATE_RESET);
         default: return urs_filt_pkg::CSR_DATA_W'($urandom_range(0, 1023));
      endcase
   endfunction

   // zero history counts in the average right after reset
   task automatic test_warmup();
      send_echo('0);
      send_echo('1);
      send_echo(16'd1);
      send_echo(16'h8000);
      send_echo(16'h7fff);
      send_echo(16'haaaa);
      send_echo(16'h5555);
   endtask

   task automatic test_register_extremes();
      drain_results();
      write_reg(urs_filt_pkg::REG_SOUND_SPEED, urs_filt_pkg::CSR_DATA_W'(1023));
      write_reg(urs_filt_pkg::REG_SAMPLE_RATE, urs_filt_pkg::CSR_DATA_W'(255));
      repeat (3) send_echo('1);
      repeat (3) send_echo('0);
      drain_results();
      write_reg(urs_filt_pkg::REG_SOUND_SPEED, '0);
      send_echo('1);
      send_echo(16'h1234);
      drain_results();
      write_reg(urs_filt_pkg::REG_SOUND_SPEED, urs_filt_pkg::CSR_DATA_W'(1));
      write_reg(urs_filt_pkg::REG_SAMPLE_RATE, '0);
      send_echo('1);
      send_echo(16'd3);
      drain_results();
      write_reg(urs_filt_pkg::REG_SAMPLE_RATE, urs_filt_pkg::CSR_DATA_W'(1));
      write_reg(urs_filt_pkg::CSR_IDX_W'(2), '1);
      write_reg(urs_filt_pkg::CSR_IDX_W'(3), '1);
      send_echo(16'd7);
      send_echo('1);
   endtask

   task automatic test_random_settings();
      for (int ph = 0; ph < 12; ph++) begin
         drain_results();
         idle_on = (ph % 3 != 2);
         write_reg(urs_filt_pkg::REG_SOUND_SPEED, pick_speed_setting());
         write_reg(urs_filt_pkg::REG_SAMPLE_RATE, pick_rate_setting());
         if ($urandom_range(0, 3) == 0)
            write_reg(urs_filt_pkg::CSR_IDX_W'($urandom_range(2, 3)),
                      urs_filt_pkg::CSR_DATA_W'($urandom_range(0, 1023)));
         repeat (125) send_echo(random_echo());
      end
      idle_on = 1'b1;
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_echo_time_us = '0;
      csr_write_en     = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      snd_speed        = urs_filt_pkg::SOUND_SPEED_RESET;
      smp_rate         = urs_filt_pkg::SAMPLE_RATE_RESET;
      for (int i = 0; i < urs_filt_pkg::WINDOW; i++) begin
         range_hist[i] = '0;
         speed_hist[i] = '0;
      end
      wr_slot        = 0;
      last_avg_range = '0;
      error_count    = 0;
      item_count     = 0;
      result_count   = 0;
      setting_count  = 0;
      idle_on        = 1'b1;
      drift_echo     = 16'd3000;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_warmup();
      test_register_extremes();
      test_random_settings();
      drain_results();

      $display("covered %0d echo transfers, %0d result transfers, %0d register writes",
               item_count, result_count, setting_count);
      $display("including warm-up, zero and full-scale registers, ignored indexes");
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Verification failed");
      $finish;
   end

endmodule
